### hdl/assert_macros.svh
// Assertion macros shared by the segmentation block.
// Needs clk and rst in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ALS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alsg: same-cycle check failed");
// next-cycle implication
`define ALS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alsg: next-cycle check failed");
`endif

### hdl/alsg_pkg.sv
// Package for adaptive_length_segmentation: widths, register codes,
// controller states and the command/status bundles. No dependencies.
package alsg_pkg;
  localparam int LEN_W      = 11;
  localparam int MINL_W     = 10;
  localparam int SER_W      = 24;
  localparam int TGT_W      = 5;
  localparam int IDX_W      = 4;
  localparam int COV_W      = 5;
  localparam int WGT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_MAX_LEN      = 1024;
  localparam int DEF_MAX_SEGMENTS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADAPTIVE_MODE  = 3'd0,
    REG_MIN_LENGTH     = 3'd1,
    REG_MAX_LENGTH     = 3'd2,
    REG_SERIES_LENGTH  = 3'd3,
    REG_SEGMENT_TARGET = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_UFILL,
    S_WSUM,
    S_SCAN,
    S_FINAL,
    S_SRD,
    S_SCMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic prep;
    logic div_start;
    logic ufill_step;
    logic wsum_step;
    logic scan_step;
    logic final_write;
    logic set_valid;
    logic search_init;
    logic search_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic table_valid;
    logic adaptive;
    logic div_busy;
    logic div_done;
    logic ufill_last;
    logic wsum_last;
    logic scan_cut;
    logic scan_final;
    logic go_on;
    logic out_free;
  } sts_t;
endpackage

### hdl/alsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alsg_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### hdl/alsg_div.sv
// Restoring divider, one quotient bit per cycle, narrow divisor.
// No dependencies.
module alsg_div #(
  parameter int DW = 48,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          busy,
  output logic          done
);
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[DW-2:0], fits};
      rem      <= fits ? VW'(trial - {1'b0, divisor}) : VW'(trial);
    end
  end
endmodule

### hdl/alsg_ctrl.sv
// Controller for the segmentation block: table rebuild and query sequence.
// Depends on alsg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module alsg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  alsg_pkg::sts_t sts,
  output alsg_pkg::cmd_t cmd
);
  import alsg_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.table_valid) begin
          cmd.search_init = 1'b1;
          state_next      = S_SRD;
        end else begin
          cmd.prep   = 1'b1;
          state_next = sts.adaptive ? S_WSUM : S_DIV_START;
        end
      end
      S_WSUM: begin
        cmd.wsum_step = 1'b1;
        if (sts.wsum_last) begin
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = sts.adaptive ? S_SCAN : S_UFILL;
        end
      end
      S_UFILL: begin
        cmd.ufill_step = 1'b1;
        if (sts.ufill_last) begin
          cmd.set_valid   = 1'b1;
          cmd.search_init = 1'b1;
          state_next      = S_SRD;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_final) begin
          state_next = S_FINAL;
        end else if (sts.scan_cut) begin
          state_next = S_DIV_START;
        end
      end
      S_FINAL: begin
        cmd.final_write = 1'b1;
        cmd.set_valid   = 1'b1;
        cmd.search_init = 1'b1;
        state_next      = S_SRD;
      end
      S_SRD: begin
        state_next = S_SCMP;
      end
      S_SCMP: begin
        cmd.search_step = 1'b1;
        state_next      = sts.go_on ? S_SRD : S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ALS_ASSERT_NEXT(a_accept_to_check, in_valid && !in_stall, state == S_CHECK)
  `ALS_ASSERT_IMPL(a_search_on_valid_table, state == S_SRD, sts.table_valid)
  `ALS_ASSERT_IMPL(a_scan_divider_idle, state == S_SCAN, !sts.div_busy)
endmodule

### hdl/alsg_dp.sv
// Datapath: configuration registers, weight sums, segment tables, search
// and output register. Depends on alsg_pkg, alsg_div and alsg_ram.
module alsg_dp #(
  parameter int MAX_LEN      = alsg_pkg::DEF_MAX_LEN,
  parameter int MAX_SEGMENTS = alsg_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [alsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [alsg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [alsg_pkg::LEN_W-1:0]        query_length,
  input  logic [alsg_pkg::IDX_W-1:0]        segment_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [alsg_pkg::COV_W-1:0]        segments_covered,
  output logic [alsg_pkg::LEN_W-1:0]        segment_length,
  output logic                              index_invalid,
  input  alsg_pkg::cmd_t                    cmd,
  output alsg_pkg::sts_t                    sts
);
  import alsg_pkg::*;

  localparam int SCW     = $clog2(MAX_SEGMENTS + 1);
  localparam int IW      = $clog2(MAX_SEGMENTS);
  localparam int TGT_RST = (MAX_SEGMENTS < 8) ? MAX_SEGMENTS : 8;

  // configuration
  logic              adaptive_mode;
  logic [MINL_W-1:0] min_length;
  logic [LEN_W-1:0]  max_length;
  logic [SER_W-1:0]  series_length;
  logic [TGT_W-1:0]  segment_target;
  logic              table_valid;
  logic              cfg_hit;
  logic [TGT_W-1:0]  tgt_wr;

  // rebuild state
  logic              mode;
  logic [LEN_W-1:0]  emax, emin;
  logic [SER_W-1:0]  ser;
  logic [SCW-1:0]    tgt, remaining, n, count, lb, cov;
  logic [LEN_W-1:0]  l, end_acc, ulen;
  logic [LEN_W:0]    start;
  logic [WGT_W-1:0]  p, total, acc;

  // query
  logic [LEN_W-1:0]  q;
  logic [IDX_W-1:0]  idx;

  logic [LEN_W-1:0]  emax_c, emin_c, len_u, q_c, end_rd, len_rd;
  logic [SER_W-1:0]  ser_c;
  logic [WGT_W-1:0]  step_w, p_inc, acc_sum, goal;
  logic              cut, le, go_on, invalid;
  logic [SCW-1:0]    cov_c;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [LEN_W-1:0]  wr_end, wr_len;

  logic              div_busy, div_done;
  logic [WGT_W-1:0]  div_dividend;
  logic [SCW-1:0]    div_divisor;

  assign tgt_wr = TGT_W'(cfg_data);

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_index)
      REG_ADAPTIVE_MODE, REG_MIN_LENGTH, REG_MAX_LENGTH, REG_SERIES_LENGTH: begin
        cfg_hit = 1'b1;
      end
      REG_SEGMENT_TARGET: begin
        cfg_hit = (tgt_wr >= TGT_W'(2)) && (int'(tgt_wr) <= MAX_SEGMENTS);
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_mode  <= 1'b1;
      min_length     <= MINL_W'(1);
      max_length     <= LEN_W'(1024);
      series_length  <= SER_W'(1024);
      segment_target <= TGT_W'(TGT_RST);
      table_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_hit) begin
        table_valid <= 1'b0;
        case (cfg_index)
          REG_ADAPTIVE_MODE:  adaptive_mode  <= cfg_data[0];
          REG_MIN_LENGTH:     min_length     <= MINL_W'(cfg_data);
          REG_MAX_LENGTH:     max_length     <= LEN_W'(cfg_data);
          REG_SERIES_LENGTH:  series_length  <= SER_W'(cfg_data);
          REG_SEGMENT_TARGET: segment_target <= tgt_wr;
          default: begin
          end
        endcase
      end else if (cmd.set_valid) begin
        table_valid <= 1'b1;
      end
    end
  end

  // clamped bounds
  always_comb begin
    emax_c = max_length;
    if (max_length < LEN_W'(2)) emax_c = LEN_W'(2);
    if (int'(max_length) > MAX_LEN) emax_c = LEN_W'(MAX_LEN);
    emin_c = (min_length == '0) ? LEN_W'(1) : LEN_W'(min_length);
    if (emin_c >= emax_c) emin_c = emax_c - 1'b1;
    ser_c = (series_length < SER_W'(emax_c)) ? SER_W'(emax_c) : series_length;
  end

  assign step_w  = WGT_W'(ser) + WGT_W'(1) - WGT_W'(l);
  assign p_inc   = (l >= emin) ? p + step_w : p;
  assign acc_sum = acc + p;
  assign cut     = acc_sum >= goal;
  assign len_u   = LEN_W'(goal);
  assign q_c     = (q > emax) ? emax : q;
  assign le      = end_rd <= q_c;

  always_comb begin
    if (mode) begin
      go_on = ((lb + 1'b1) < count) && (end_rd < q_c);
      cov_c = (end_rd == q_c) ? lb + 1'b1 : lb;
    end else begin
      go_on = le && ((lb + 1'b1) < count);
      cov_c = (ulen == '0) ? '0 : (le ? lb + 1'b1 : lb);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      q   <= query_length;
      idx <= segment_index;
    end
    if (cmd.prep) begin
      mode      <= adaptive_mode;
      emax      <= emax_c;
      emin      <= emin_c;
      ser       <= ser_c;
      tgt       <= SCW'(segment_target);
      remaining <= SCW'(segment_target);
      l         <= emax_c;
      p         <= '0;
      total     <= '0;
      acc       <= '0;
      n         <= '0;
      start     <= (LEN_W+1)'(1);
      end_acc   <= '0;
    end
    if (cmd.wsum_step) begin
      p     <= p_inc;
      total <= total + p_inc;
      l     <= (l == LEN_W'(1)) ? LEN_W'(1) : l - 1'b1;
    end
    if (cmd.ufill_step) begin
      end_acc <= end_acc + len_u;
      n       <= n + 1'b1;
      if (sts.ufill_last) begin
        count <= tgt;
        ulen  <= len_u;
      end
    end
    if (cmd.scan_step) begin
      total <= total - p;
      if (l >= emin) p <= p - step_w;
      l <= l + 1'b1;
      if (cut) begin
        acc       <= '0;
        n         <= n + 1'b1;
        start     <= {1'b0, l} + 1'b1;
        remaining <= remaining - 1'b1;
      end else begin
        acc <= acc_sum;
      end
    end
    if (cmd.final_write) begin
      count <= n + 1'b1;
    end
    if (cmd.search_init) begin
      lb <= '0;
    end
    if (cmd.search_step) begin
      cov <= cov_c;
      if (go_on) lb <= lb + 1'b1;
    end
  end

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IW'(n);
    wr_end  = l;
    wr_len  = LEN_W'({1'b0, l} - start + 1'b1);
    if (cmd.ufill_step) begin
      wr_en  = 1'b1;
      wr_end = end_acc + len_u;
      wr_len = len_u;
    end else if (cmd.scan_step) begin
      wr_en = cut;
    end else if (cmd.final_write) begin
      wr_en  = 1'b1;
      wr_end = emax;
      wr_len = LEN_W'({1'b0, emax} - start + 1'b1);
    end
  end

  assign div_dividend = mode ? total : WGT_W'(emax);
  assign div_divisor  = mode ? remaining : tgt;

  alsg_div #(.DW(WGT_W), .VW(SCW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (goal),
    .busy     (div_busy),
    .done     (div_done)
  );

  alsg_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SEGMENTS)) u_end_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_end),
    .rd_addr (IW'(lb)),
    .rd_data (end_rd)
  );

  alsg_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SEGMENTS)) u_len_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_len),
    .rd_addr (IW'(idx)),
    .rd_data (len_rd)
  );

  assign invalid = int'(idx) >= int'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      segments_covered <= COV_W'(cov);
      segment_length   <= invalid ? '0 : len_rd;
      index_invalid    <= invalid;
    end
  end

  assign sts.table_valid = table_valid;
  assign sts.adaptive    = cmd.prep ? adaptive_mode : mode;
  assign sts.div_busy    = div_busy;
  assign sts.div_done    = div_done;
  assign sts.ufill_last  = (n == tgt - 1'b1);
  assign sts.wsum_last   = (l == LEN_W'(1));
  assign sts.scan_cut    = cut;
  assign sts.scan_final  = (l == emax) || (cut && (remaining == SCW'(2)));
  assign sts.go_on       = go_on;
  assign sts.out_free    = !out_valid || !out_stall;
endmodule

### hdl/adaptive_length_segmentation.sv
// Top level: alsg_ctrl and alsg_dp joined by command/status; needs alsg_pkg.
// A query checks the table, then reads and compares segment ends (at most count),
// then loads the result once the output is free; one query in flight, the next
// request is taken once the controller is back in idle. After reset or an accepted
// register write, the first query rebuilds the table (48-bit serial divider).
// Synchronous reset restores register defaults, marks table stale.
module adaptive_length_segmentation #(
  parameter int MAX_LEN      = alsg_pkg::DEF_MAX_LEN,
  parameter int MAX_SEGMENTS = alsg_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [alsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alsg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [alsg_pkg::LEN_W-1:0]      query_length,
  input  logic [alsg_pkg::IDX_W-1:0]      segment_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [alsg_pkg::COV_W-1:0]      segments_covered,
  output logic [alsg_pkg::LEN_W-1:0]      segment_length,
  output logic                            index_invalid
);
  import alsg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  alsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  alsg_dp #(.MAX_LEN(MAX_LEN), .MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .query_length     (query_length),
    .segment_index    (segment_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .segments_covered (segments_covered),
    .segment_length   (segment_length),
    .index_invalid    (index_invalid),
    .cmd              (cmd),
    .sts              (sts)
  );
endmodule
